// ===== src/rsi_pkg.sv =====
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int VALUE_W = 32;
  localparam int FRAC_W = 16;
  localparam int OC_W = VALUE_W + 1;
  localparam int PROD_W = 2 * OC_W;
  localparam int A_W = 2 * VALUE_W + 1;
  localparam int B_W = 2 * VALUE_W + 3;
  localparam int C_W = B_W;
  localparam int DISC_W = 2 * B_W;
  localparam int SQ_W = DISC_W / 2;
  localparam int DIFF_W = 2 * VALUE_W + 5;
  localparam int MAG_W = DIFF_W - 1 + FRAC_W;
  localparam int DVS_W = A_W;
  localparam int MUL_LAT = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic signed [VALUE_W-1:0] MISS_DIST = VALUE_W'(-(longint'(1) << FRAC_W));
  localparam logic signed [VALUE_W-1:0] DIST_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] DIST_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] origin_x;
    logic signed [VALUE_W-1:0] origin_y;
    logic signed [VALUE_W-1:0] origin_z;
    logic signed [VALUE_W-1:0] dir_x;
    logic signed [VALUE_W-1:0] dir_y;
    logic signed [VALUE_W-1:0] dir_z;
    logic signed [VALUE_W-1:0] center_x;
    logic signed [VALUE_W-1:0] center_y;
    logic signed [VALUE_W-1:0] center_z;
    logic [VALUE_W-2:0]        sphere_radius;
  } rsi_in_t;

  typedef struct packed {
    logic                      hit;
    logic                      touch;
    logic                      zero_direction;
    logic                      saturated;
    logic signed [VALUE_W-1:0] distance;
  } rsi_out_t;

  typedef struct packed {
    logic hit;
    logic touch;
    logic zdir;
  } rsi_flags_t;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    rsi_flags_t            flags;
    logic [DISC_W-1:0]     disc;
    logic signed [B_W-1:0] b;
    logic [A_W-2:0]        a;
  } rsi_entry_t;

endpackage

// ===== src/ray_sphere_intersection_core.sv =====
`timescale 1ns / 1ps
// Ray-sphere test on Q16.16 operands, one ray/sphere pair per beat and one result per beat.
// A beat is taken on a clock edge with start high and busy low; each result appears on
// out_item for one cycle with out_valid high and cannot be held off. The block takes a new
// beat every cycle and returns the results in the order the beats were taken. The front end
// forms oc, a, b, c and the discriminant with pipelined 32-bit partial-product multipliers
// and classifies the beat; a four-entry queue hands it to the back end, where a 67-stage
// square-root pipeline and an 84-stage divider pipeline set the latency. The back end never
// stalls, so the queue drains as fast as it fills and busy stays low in operation.
module ray_sphere_intersection_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rsi_pkg::rsi_in_t  in_item,
  output logic              out_valid,
  output rsi_pkg::rsi_out_t out_item
);

  logic                q_push, q_valid, q_full;
  rsi_pkg::rsi_entry_t q_in, q_out;

  rsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid_i(start && !busy),
    .in_item_i (in_item),
    .push_o    (q_push),
    .entry_o   (q_in)
  );

  rsi_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_valid),
    .valid_o(q_valid),
    .full_o (q_full),
    .data_o (q_out)
  );

  rsi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (q_valid),
    .entry_i    (q_out),
    .out_valid_o(out_valid),
    .out_item_o (out_item)
  );

  assign busy = q_full;

endmodule

// ===== src/rsi_mul.sv =====
`timescale 1ns / 1ps
module rsi_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int CH = 32;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;
  localparam int RW = (NA + NB) * CH;

  logic          neg0_r, neg1_r, neg2_r, neg3_r;
  logic [AW-1:0] ma_r;
  logic [BW-1:0] mb_r;
  logic [NA*CH-1:0] ma_pad;
  logic [NB*CH-1:0] mb_pad;
  logic [2*CH-1:0] pp_nxt [NA][NB];
  logic [2*CH-1:0] pp_r   [NA][NB];
  logic [RW-1:0]   row_nxt [NA];
  logic [RW-1:0]   row_r   [NA];
  logic [RW-1:0]   sum_nxt;
  logic [RW-1:0]   sum_r;
  logic signed [PW-1:0] p_r;

  // Sign and magnitude first, so the partial products are plain unsigned 32x32.
  always_ff @(posedge clk) begin
    neg0_r <= a_i[AW-1] ^ b_i[BW-1];
    ma_r   <= a_i[AW-1] ? $unsigned(-a_i) : $unsigned(a_i);
    mb_r   <= b_i[BW-1] ? $unsigned(-b_i) : $unsigned(b_i);
  end

  assign ma_pad = (NA*CH)'(ma_r);
  assign mb_pad = (NB*CH)'(mb_r);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_nxt[i][j] = (2*CH)'(ma_pad[i*CH +: CH]) * (2*CH)'(mb_pad[j*CH +: CH]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * CH));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (row_r[i] << (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    pp_r   <= pp_nxt;
    neg1_r <= neg0_r;
    row_r  <= row_nxt;
    neg2_r <= neg1_r;
    sum_r  <= sum_nxt;
    neg3_r <= neg2_r;
    p_r    <= neg3_r ? -$signed(PW'(sum_r)) : $signed(PW'(sum_r));
  end

  assign p_o = p_r;

endmodule

// ===== src/rsi_front.sv =====
`timescale 1ns / 1ps
module rsi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  input  rsi_pkg::rsi_in_t    in_item_i,
  output logic                push_o,
  output rsi_pkg::rsi_entry_t entry_o
);

  localparam int OC_W = rsi_pkg::OC_W;
  localparam int PROD_W = rsi_pkg::PROD_W;
  localparam int A_W = rsi_pkg::A_W;
  localparam int B_W = rsi_pkg::B_W;
  localparam int C_W = rsi_pkg::C_W;
  localparam int DISC_W = rsi_pkg::DISC_W;
  localparam int LAT = rsi_pkg::MUL_LAT;

  logic v0_r;
  logic signed [OC_W-1:0] oc_r [3];
  logic signed [OC_W-1:0] d_r  [3];
  logic signed [OC_W-1:0] rad_r;

  logic signed [PROD_W-1:0] sq_d  [3];
  logic signed [PROD_W-1:0] dot_p [3];
  logic signed [PROD_W-1:0] sq_oc [3];
  logic signed [PROD_W-1:0] sq_r;
  logic v_m1_r [LAT];

  logic v1_r, v2_r, v3_r, push_r;
  logic signed [A_W-1:0] a1_r, a2_r, a3_r;
  logic signed [B_W-1:0] dot1_r, b2_r, b3_r;
  logic signed [C_W-1:0] occ1_r, rr1_r, c2_r;

  logic signed [DISC_W-1:0]     bb;
  logic signed [A_W+C_W-1:0]    ac;
  logic signed [A_W-1:0] a_dl_r [LAT];
  logic signed [B_W-1:0] b_dl_r [LAT];
  logic                  v_m2_r [LAT];
  logic signed [DISC_W-1:0] disc3_r;
  rsi_pkg::rsi_entry_t entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    oc_r[0] <= OC_W'(in_item_i.origin_x) - OC_W'(in_item_i.center_x);
    oc_r[1] <= OC_W'(in_item_i.origin_y) - OC_W'(in_item_i.center_y);
    oc_r[2] <= OC_W'(in_item_i.origin_z) - OC_W'(in_item_i.center_z);
    d_r[0]  <= OC_W'(in_item_i.dir_x);
    d_r[1]  <= OC_W'(in_item_i.dir_y);
    d_r[2]  <= OC_W'(in_item_i.dir_z);
    rad_r   <= $signed({2'b00, in_item_i.sphere_radius});
  end

  for (genvar k = 0; k < 3; k++) begin : g_bank1
    rsi_mul #(.AW(OC_W), .BW(OC_W)) u_dd (.clk(clk), .a_i(d_r[k]), .b_i(d_r[k]), .p_o(sq_d[k]));
    rsi_mul #(.AW(OC_W), .BW(OC_W)) u_od (.clk(clk), .a_i(oc_r[k]), .b_i(d_r[k]), .p_o(dot_p[k]));
    rsi_mul #(.AW(OC_W), .BW(OC_W)) u_oo (.clk(clk), .a_i(oc_r[k]), .b_i(oc_r[k]), .p_o(sq_oc[k]));
  end
  rsi_mul #(.AW(OC_W), .BW(OC_W)) u_rr (.clk(clk), .a_i(rad_r), .b_i(rad_r), .p_o(sq_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        v_m1_r[k] <= 1'b0;
        v_m2_r[k] <= 1'b0;
      end
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      push_r <= 1'b0;
    end else begin
      v_m1_r[0] <= v0_r;
      v_m2_r[0] <= v2_r;
      for (int k = 1; k < LAT; k++) begin
        v_m1_r[k] <= v_m1_r[k-1];
        v_m2_r[k] <= v_m2_r[k-1];
      end
      v1_r   <= v_m1_r[LAT-1];
      v2_r   <= v1_r;
      v3_r   <= v_m2_r[LAT-1];
      push_r <= v3_r;
    end
  end

  // The sum of three squares of oc can reach 3 * 2^64, so it is widened first.
  always_ff @(posedge clk) begin
    a1_r   <= A_W'(sq_d[0]) + A_W'(sq_d[1]) + A_W'(sq_d[2]);
    dot1_r <= B_W'(dot_p[0]) + B_W'(dot_p[1]) + B_W'(dot_p[2]);
    occ1_r <= C_W'(sq_oc[0]) + C_W'(sq_oc[1]) + C_W'(sq_oc[2]);
    rr1_r  <= C_W'(sq_r);
    a2_r   <= a1_r;
    b2_r   <= dot1_r <<< 1;
    c2_r   <= occ1_r - rr1_r;
  end

  rsi_mul #(.AW(B_W), .BW(B_W)) u_bb (.clk(clk), .a_i(b2_r), .b_i(b2_r), .p_o(bb));
  rsi_mul #(.AW(A_W), .BW(C_W)) u_ac (.clk(clk), .a_i(a2_r), .b_i(c2_r), .p_o(ac));

  always_ff @(posedge clk) begin
    a_dl_r[0] <= a2_r;
    b_dl_r[0] <= b2_r;
    for (int k = 1; k < LAT; k++) begin
      a_dl_r[k] <= a_dl_r[k-1];
      b_dl_r[k] <= b_dl_r[k-1];
    end
    disc3_r <= bb - (DISC_W'(ac) <<< 2);
    a3_r    <= a_dl_r[LAT-1];
    b3_r    <= b_dl_r[LAT-1];
  end

  always_ff @(posedge clk) begin
    entry_r.flags.touch <= ~disc3_r[DISC_W-1];
    entry_r.flags.hit   <= ~disc3_r[DISC_W-1] & (|disc3_r);
    entry_r.flags.zdir  <= (a3_r == '0);
    entry_r.disc        <= disc3_r;
    entry_r.b           <= b3_r;
    entry_r.a           <= a3_r[A_W-2:0];
  end

  assign push_o  = push_r;
  assign entry_o = entry_r;

endmodule

// ===== src/rsi_queue.sv =====
`timescale 1ns / 1ps
module rsi_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  rsi_pkg::rsi_entry_t data_i,
  input  logic                pop_i,
  output logic                valid_o,
  output logic                full_o,
  output rsi_pkg::rsi_entry_t data_o
);

  localparam int DEPTH = rsi_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsi_pkg::rsi_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign do_push = push_i && (count_r != CNT_W'(DEPTH));
  assign do_pop  = pop_i && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = do_push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  assign valid_o = (count_r != '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign data_o  = mem_r[rd_ptr_r];

endmodule

// ===== src/rsi_back.sv =====
`timescale 1ns / 1ps
module rsi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid_i,
  input  rsi_pkg::rsi_entry_t entry_i,
  output logic                out_valid_o,
  output rsi_pkg::rsi_out_t   out_item_o
);

  localparam int VALUE_W = rsi_pkg::VALUE_W;
  localparam int FRAC_W = rsi_pkg::FRAC_W;
  localparam int A_W = rsi_pkg::A_W;
  localparam int B_W = rsi_pkg::B_W;
  localparam int DISC_W = rsi_pkg::DISC_W;
  localparam int SQ_W = rsi_pkg::SQ_W;
  localparam int REM_W = SQ_W + 3;
  localparam int DIFF_W = rsi_pkg::DIFF_W;
  localparam int MAG_W = rsi_pkg::MAG_W;
  localparam int DVS_W = rsi_pkg::DVS_W;
  localparam logic signed [MAG_W:0] Q_MAX = (MAG_W+1)'(rsi_pkg::DIST_MAX);
  localparam logic signed [MAG_W:0] Q_MIN = (MAG_W+1)'(rsi_pkg::DIST_MIN);

  // Square root: two radicand bits per stage, one root bit per stage.
  logic                   sq_v_r    [SQ_W+1];
  logic [REM_W-1:0]       sq_rem_r  [SQ_W+1];
  logic [SQ_W-1:0]        sq_root_r [SQ_W+1];
  logic [DISC_W-1:0]      sq_src_r  [SQ_W+1];
  logic signed [B_W-1:0]  sq_b_r    [SQ_W+1];
  logic [A_W-2:0]         sq_a_r    [SQ_W+1];
  rsi_pkg::rsi_flags_t    sq_f_r    [SQ_W+1];

  logic                     n1_v_r;
  logic signed [DIFF_W-1:0] diff_nxt, diff_r;
  logic [A_W-2:0]           n1_a_r;
  rsi_pkg::rsi_flags_t      n1_f_r;
  logic [DIFF_W-1:0]        diff_abs;

  // Restoring divider: one quotient bit per stage.
  logic                dv_v_r   [MAG_W+1];
  logic [DVS_W-1:0]    dv_rem_r [MAG_W+1];
  logic [MAG_W-1:0]    dv_src_r [MAG_W+1];
  logic [MAG_W-1:0]    dv_q_r   [MAG_W+1];
  logic [DVS_W-1:0]    dv_dvs_r [MAG_W+1];
  logic                dv_neg_r [MAG_W+1];
  rsi_pkg::rsi_flags_t dv_f_r   [MAG_W+1];

  logic                  e1_v_r;
  logic signed [MAG_W:0] qs_nxt, qs_r;
  rsi_pkg::rsi_flags_t   e1_f_r;
  logic                  rem_zero;

  logic              out_valid_r;
  rsi_pkg::rsi_out_t out_item_r, out_item_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_src_r[0]  <= entry_i.disc;
    sq_b_r[0]    <= entry_i.b;
    sq_a_r[0]    <= entry_i.a;
    sq_f_r[0]    <= entry_i.flags;
  end

  for (genvar k = 0; k < SQ_W; k++) begin : g_sq
    logic [REM_W-1:0] t, trial;
    logic             ge;

    assign t     = {sq_rem_r[k][REM_W-3:0], sq_src_r[k][DISC_W-1 -: 2]};
    assign trial = REM_W'({sq_root_r[k], 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[k+1]  <= ge ? REM_W'(t - trial) : t;
      sq_root_r[k+1] <= {sq_root_r[k][SQ_W-2:0], ge};
      sq_src_r[k+1]  <= {sq_src_r[k][DISC_W-3:0], 2'b00};
      sq_b_r[k+1]    <= sq_b_r[k];
      sq_a_r[k+1]    <= sq_a_r[k];
      sq_f_r[k+1]    <= sq_f_r[k];
    end
  end

  assign diff_nxt = -DIFF_W'(sq_b_r[SQ_W]) - DIFF_W'($signed({1'b0, sq_root_r[SQ_W]}));
  assign diff_abs = diff_r[DIFF_W-1] ? $unsigned(-diff_r) : $unsigned(diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r    <= 1'b0;
      dv_v_r[0] <= 1'b0;
    end else begin
      n1_v_r    <= sq_v_r[SQ_W];
      dv_v_r[0] <= n1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r      <= diff_nxt;
    n1_a_r      <= sq_a_r[SQ_W];
    n1_f_r      <= sq_f_r[SQ_W];
    dv_rem_r[0] <= '0;
    dv_src_r[0] <= {diff_abs[DIFF_W-2:0], {FRAC_W{1'b0}}};
    dv_q_r[0]   <= '0;
    dv_dvs_r[0] <= {n1_a_r, 1'b0};
    dv_neg_r[0] <= diff_r[DIFF_W-1];
    dv_f_r[0]   <= n1_f_r;
  end

  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    logic [DVS_W:0] t, sub;
    logic           ge;

    assign t   = {dv_rem_r[k], dv_src_r[k][MAG_W-1]};
    assign sub = t - {1'b0, dv_dvs_r[k]};
    assign ge  = (t >= {1'b0, dv_dvs_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k+1] <= 1'b0;
      end else begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1] <= ge ? sub[DVS_W-1:0] : t[DVS_W-1:0];
      dv_src_r[k+1] <= {dv_src_r[k][MAG_W-2:0], 1'b0};
      dv_q_r[k+1]   <= {dv_q_r[k][MAG_W-2:0], ge};
      dv_dvs_r[k+1] <= dv_dvs_r[k];
      dv_neg_r[k+1] <= dv_neg_r[k];
      dv_f_r[k+1]   <= dv_f_r[k];
    end
  end

  // Floor of a negative quotient: -q when exact, otherwise -q - 1, which is ~q.
  assign rem_zero = (dv_rem_r[MAG_W] == '0);
  assign qs_nxt = dv_neg_r[MAG_W]
                ? $signed((~{1'b0, dv_q_r[MAG_W]}) + (MAG_W+1)'(rem_zero))
                : $signed({1'b0, dv_q_r[MAG_W]});

  always_comb begin
    out_item_nxt.hit            = e1_f_r.hit;
    out_item_nxt.touch          = e1_f_r.touch;
    out_item_nxt.zero_direction = e1_f_r.zdir;
    out_item_nxt.saturated      = 1'b0;
    out_item_nxt.distance       = rsi_pkg::MISS_DIST;
    if (e1_f_r.touch && !e1_f_r.zdir) begin
      if (qs_r > Q_MAX) begin
        out_item_nxt.distance  = rsi_pkg::DIST_MAX;
        out_item_nxt.saturated = 1'b1;
      end else if (qs_r < Q_MIN) begin
        out_item_nxt.distance  = rsi_pkg::DIST_MIN;
        out_item_nxt.saturated = 1'b1;
      end else begin
        out_item_nxt.distance = qs_r[VALUE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      e1_v_r      <= dv_v_r[MAG_W];
      out_valid_r <= e1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    qs_r       <= qs_nxt;
    e1_f_r     <= dv_f_r[MAG_W];
    out_item_r <= out_item_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_item_o  = out_item_r;

endmodule

// ===== src/rsi_checker.sv =====
`timescale 1ns / 1ps
module rsi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input rsi_pkg::rsi_out_t out_item
);

  // The back end drains the queue every cycle, so it can never fill.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.touch |->
      !out_item.hit && !out_item.saturated && out_item.distance == rsi_pkg::MISS_DIST)
    else $error("miss result malformed");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_direction |->
      out_item.touch && !out_item.hit && !out_item.saturated &&
      out_item.distance == rsi_pkg::MISS_DIST)
    else $error("zero direction result malformed");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.saturated |->
      out_item.distance == rsi_pkg::DIST_MAX || out_item.distance == rsi_pkg::DIST_MIN)
    else $error("saturated distance not at a bound");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind ray_sphere_intersection_core rsi_checker u_rsi_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  typedef logic signed [255:0] wide_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int RANDOM_ITEMS   = 950;

  logic              clk;
  logic              rst_n;
  logic              start = 1'b0;
  logic              busy;
  rsi_pkg::rsi_in_t  in_item = '0;
  logic              out_valid;
  rsi_pkg::rsi_out_t out_item;

  rsi_pkg::rsi_in_t  ray_pending[$];
  rsi_pkg::rsi_out_t hit_expected[$];
  int       idle_pct;
  int       fail_count = 0;
  int       beats_sent = 0;
  int       results_seen = 0;
  int       hits_seen = 0;
  int       sats_seen = 0;
  int       quiet_cycles = 0;

  ray_sphere_intersection_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic wide_t isqrt_floor(wide_t d);
    wide_t r;
    wide_t cand;
    r = '0;
    for (int bit_i = 119; bit_i >= 0; bit_i--) begin
      cand = r;
      cand[bit_i] = 1'b1;
      if (cand * cand <= d) r = cand;
    end
    return r;
  endfunction

  // Exact integer version of the quadratic; the near root is floored.
  function automatic rsi_pkg::rsi_out_t predict_intersection(rsi_pkg::rsi_in_t ray);
    rsi_pkg::rsi_out_t res;
    wide_t ocx, ocy, ocz, dx, dy, dz, rad;
    wide_t qa, qb, qc, disc, num, den, quo;
    wide_t dist_hi, dist_lo;
    ocx = wide_t'(ray.origin_x) - wide_t'(ray.center_x);
    ocy = wide_t'(ray.origin_y) - wide_t'(ray.center_y);
    ocz = wide_t'(ray.origin_z) - wide_t'(ray.center_z);
    dx = wide_t'(ray.dir_x);
    dy = wide_t'(ray.dir_y);
    dz = wide_t'(ray.dir_z);
    rad = wide_t'({1'b0, ray.sphere_radius});
    qa = dx * dx + dy * dy + dz * dz;
    qb = (ocx * dx + ocy * dy + ocz * dz) * 2;
    qc = ocx * ocx + ocy * ocy + ocz * ocz - rad * rad;
    disc = qb * qb - qa * qc * 4;
    res = '0;
    res.hit = disc > 0;
    res.touch = disc >= 0;
    res.zero_direction = qa == 0;
    res.distance = rsi_pkg::MISS_DIST;
    if (res.touch && !res.zero_direction) begin
      num = (-qb - isqrt_floor(disc)) * (wide_t'(1) <<< rsi_pkg::FRAC_W);
      den = qa * 2;
      quo = num / den;
      if (num < 0 && (num % den) != 0) quo = quo - 1;
      dist_hi = wide_t'(rsi_pkg::DIST_MAX);
      dist_lo = wide_t'(rsi_pkg::DIST_MIN);
      if (quo > dist_hi) begin
        quo = dist_hi;
        res.saturated = 1'b1;
      end
      if (quo < dist_lo) begin
        quo = dist_lo;
        res.saturated = 1'b1;
      end
      res.distance = quo[rsi_pkg::VALUE_W-1:0];
    end
    return res;
  endfunction

  function automatic rsi_pkg::rsi_in_t make_ray(int ox, int oy, int oz, int dx, int dy,
                                                int dz, int cx, int cy, int cz, int rad);
    rsi_pkg::rsi_in_t r;
    r.origin_x = ox;
    r.origin_y = oy;
    r.origin_z = oz;
    r.dir_x = dx;
    r.dir_y = dy;
    r.dir_z = dz;
    r.center_x = cx;
    r.center_y = cy;
    r.center_z = cz;
    r.sphere_radius = (rsi_pkg::VALUE_W-1)'(rad);
    return r;
  endfunction

  function automatic int small_val(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Driver: a beat offered at a falling edge stays until it is taken. The monitor
  // drops a beat from the feed when it is taken, so the head is always the beat offered.
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && busy) begin
        if (ray_pending.size() > 0) begin
          in_item <= ray_pending[0];
        end else begin
          start <= 1'b0;
        end
      end else if (ray_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        in_item <= ray_pending[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: record accepted beats and check each result against the oldest prediction.
  always @(posedge clk) begin
    rsi_pkg::rsi_out_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        hit_expected.push_back(predict_intersection(in_item));
        void'(ray_pending.pop_front());
        beats_sent <= beats_sent + 1;
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (hit_expected.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = hit_expected.pop_front();
          if (out_item.hit) hits_seen <= hits_seen + 1;
          if (out_item.saturated) sats_seen <= sats_seen + 1;
          if (out_item.hit !== want.hit || out_item.touch !== want.touch ||
              out_item.zero_direction !== want.zero_direction ||
              out_item.saturated !== want.saturated ||
              out_item.distance !== want.distance) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rsi_pkg::rsi_in_t r;
    int kind;
    rst_n = 1'b0;
    idle_pct = 24;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: miss, exact tangent, zero direction, saturation both ways, field extremes.
    ray_pending.push_back(make_ray(0, 0, 0, 65536, 0, 0, 0, 10 << 16, 0, 65536));
    ray_pending.push_back(make_ray(0, 65536, 0, 65536, 0, 0, 0, 0, 0, 65536));
    ray_pending.push_back(make_ray(0, 0, 0, 65536, 0, 0, 5 << 16, 0, 0, 65536));
    ray_pending.push_back(make_ray(0, 0, 0, -65536, 0, 0, 5 << 16, 0, 0, 65536));
    ray_pending.push_back(make_ray(0, 0, 0, 0, 0, 0, 5 << 16, 0, 0, 65536));
    ray_pending.push_back(make_ray(7, -3, 9, 0, 0, 0, 7, -3, 9, 0));
    ray_pending.push_back(make_ray(0, 0, 0, 1, 0, 0, 32'h7fffffff, 0, 0, 65536));
    ray_pending.push_back(make_ray(0, 0, 0, 1, 0, 0, 32'h80000000, 0, 0, 65536));
    ray_pending.push_back(make_ray(0, 0, 0, -1, 0, 0, 32'h7fffffff, 0, 0, 65536));
    ray_pending.push_back(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    ray_pending.push_back(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    ray_pending.push_back(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 32'h7fffffff));
    ray_pending.push_back(make_ray(0, 0, 0, 1, 1, 1, 0, 0, 0, 0));
    ray_pending.push_back(make_ray(0, 0, 0, 32'h80000000, 0, 0, 0, 0, 0, 1));
    ray_pending.push_back(make_ray(0, 0, 0, 0, 0, 65536, 0, 0, 0, 32'h7fffffff));
    ray_pending.push_back(make_ray(100, 200, 300, 3 << 16, 4 << 16, 0,
                                   10 << 16, 0, 0, 2 << 16));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_pct = 64;
      if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      kind = $urandom_range(9);
      r = $bits(rsi_pkg::rsi_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom, $urandom});
      if (kind >= 3) begin
        // Origin inside or near a sphere of random size so that most rays hit.
        r.center_x = small_val(1 << 24);
        r.center_y = small_val(1 << 24);
        r.center_z = small_val(1 << 24);
        r.sphere_radius = (rsi_pkg::VALUE_W-1)'($urandom_range(1 << 22, 1));
        r.origin_x = r.center_x + small_val(1 << 22);
        r.origin_y = r.center_y + small_val(1 << 22);
        r.origin_z = r.center_z + small_val(1 << 22);
        r.dir_x = small_val(1 << 18);
        r.dir_y = small_val(1 << 18);
        r.dir_z = small_val(1 << 18);
        if (kind == 9) begin
          r.dir_x = small_val(2);
          r.dir_y = 0;
          r.dir_z = 0;
        end
      end
      // Keep the feed short so that each idle phase applies to its own beats.
      while (ray_pending.size() > 4) @(negedge clk);
      ray_pending.push_back(r);
    end
    while (ray_pending.size() > 0 || start) @(negedge clk);
    while (hit_expected.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d rays under three idle profiles; %0d results checked,", beats_sent,
             results_seen);
    $display("%0d of them hits and %0d with a clamped distance.", hits_seen, sats_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rsi_pkg.sv
src/rsi_mul.sv
src/rsi_front.sv
src/rsi_queue.sv
src/rsi_back.sv
src/ray_sphere_intersection_core.sv
src/rsi_checker.sv
dv/tb_top.sv
